[rtl/tds_pkg.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver package
// Shared widths, defaults and the saturation helper.
// ----------------------------------------------------------------------------
package tds_pkg;
  localparam int DATA_W        = 32;
  localparam int IDX_W         = 6;
  localparam int MAX_ROWS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  // Operation codes for the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV
  } op_t;

  // Saturate a 66-bit signed value to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat66(input logic signed [65:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = SAT_MAX;
    end else if (v < -66'sh0_8000_0000) begin
      r = SAT_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction
endpackage

[rtl/tds_arith.sv]
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// Fixed-point multiply (registered) and a restoring divider that
// retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tds_arith #(
  parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  tds_pkg::op_t                       op,
  input  logic signed [33:0]                 opa,
  input  logic signed [tds_pkg::DATA_W-1:0]  opb,
  output logic                               done,
  output logic signed [tds_pkg::DATA_W-1:0]  result
);
  import tds_pkg::*;

  localparam int NUM_W = 33 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [NUM_W-1:0]   quo;
  logic [32:0]        rem;
  logic [31:0]        den;
  logic               neg;

  logic signed [65:0] prod;
  logic [65:0]        pmag;
  logic [65:0]        pshift;
  logic [33:0]        rem_try;
  logic [32:0]        amag;
  logic [65:0]        qext;

  always_comb begin
    prod    = 66'(opa) * 66'(opb);
    pmag    = prod[65] ? 66'(-prod) : 66'(prod);
    pshift  = pmag >> FRAC_BITS;
    rem_try = {rem, quo[NUM_W-1]} - {2'b00, den};
    amag    = opa[33] ? 33'(-opa) : 33'(opa);
    qext    = 66'(quo);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      if (op == OP_MUL) begin
        done   <= 1'b1;
        result <= sat66(prod[65] ? -$signed(pshift) : $signed(pshift));
      end else begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        quo  <= {amag, {FRAC_BITS{1'b0}}};
        rem  <= '0;
        den  <= opb[31] ? 32'(-opb) : 32'(opb);
        neg  <= opa[33] ^ opb[31];
      end
    end else if (busy) begin
      if (cnt == '0) begin
        busy   <= 1'b0;
        done   <= 1'b1;
        result <= sat66(neg ? -$signed(qext) : $signed(qext));
      end else begin
        cnt <= cnt - 1'b1;
        if (!rem_try[33]) begin
          rem <= rem_try[32:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[NUM_W-1]};
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
      end
    end
  end
endmodule

[rtl/tridiagonal_system_solver_unit.sv]
// ----------------------------------------------------------------------------
// Tridiagonal system solver
// Thomas algorithm in signed fixed point on one shared multiply/divide unit.
// ----------------------------------------------------------------------------
// Rows enter on the input channel (lower, diag, upper, rhs_value, last_row),
// one item at a time; ready is low while a row is being worked on. Row 0
// is only stored and checked for a zero pivot. Every later row, unless a
// zero pivot has been seen, does one division and two multiplies on the
// shared unit. The row marked last, or row MAX_ROWS-1, then starts back
// substitution (skipped after a zero pivot): one multiply and one division
// per row, with only the division for the last row. Elements leave row 0
// first once all are computed, one at a time, each read only after the one
// before it is taken.
// The solution channel holds one output register; a stalled receiver holds
// the block until each element is taken. A zero pivot makes all solution
// values of that run zero with singular set. Reset returns the block to
// row 0 with no run pending; stores need no clearing.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver_unit #(
  parameter int MAX_ROWS  = tds_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [tds_pkg::DATA_W-1:0]  lower,
  input  logic signed [tds_pkg::DATA_W-1:0]  diag,
  input  logic signed [tds_pkg::DATA_W-1:0]  upper,
  input  logic signed [tds_pkg::DATA_W-1:0]  rhs_value,
  input  logic                               last_row,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tds_pkg::DATA_W-1:0]  solution,
  output logic [tds_pkg::IDX_W-1:0]          row_index,
  output logic                               singular,
  output logic                               last_result
);
  import tds_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_L, S_MUL_D, S_MUL_Y, S_WRITE,
    S_BS_RD, S_BS_MUL, S_BS_DIV, S_BS_NEXT, S_EMIT_RD, S_EMIT
  } state_t;

  state_t state;

  logic signed [DATA_W-1:0] pivot_mem [MAX_ROWS];
  logic signed [DATA_W-1:0] upper_mem [MAX_ROWS];
  logic signed [DATA_W-1:0] fwd_mem   [MAX_ROWS];
  logic signed [DATA_W-1:0] x_mem     [MAX_ROWS];

  logic [AW-1:0]            row_count;
  logic [AW-1:0]            cur;
  logic [AW-1:0]            nrows_m1;
  logic                     singular_seen;
  logic signed [DATA_W-1:0] l_low, l_diag, l_rhs, l_upper;
  logic signed [DATA_W-1:0] rd_piv, rd_up, rd_fwd, rd_x;
  logic signed [DATA_W-1:0] mult_l, new_piv, x_prev;

  logic                     a_start;
  op_t                      a_op;
  logic signed [33:0]       a_opa;
  logic signed [DATA_W-1:0] a_opb;
  logic                     a_done;
  logic signed [DATA_W-1:0] a_res;
  logic                     issued;

  // Registered numerator for back substitution, held across the divide.
  logic signed [33:0] bs_num;
  logic               bs_top;

  tds_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk(clk), .rst(rst), .start(a_start), .op(a_op), .opa(a_opa), .opb(a_opb),
    .done(a_done), .result(a_res)
  );

  assign in_ready = (state == S_IDLE);

  logic signed [33:0] diff34;
  always_comb begin
    diff34  = 34'(rd_fwd) - 34'(a_res);
    a_start = 1'b0;
    a_op    = OP_MUL;
    a_opa   = '0;
    a_opb   = '0;
    unique case (state)
      S_DIV_L:  begin a_start = !issued; a_op = OP_DIV; a_opa = 34'(l_low); a_opb = rd_piv; end
      S_MUL_D:  begin a_start = !issued; a_opa = 34'(mult_l); a_opb = rd_up; end
      S_MUL_Y:  begin a_start = !issued; a_opa = 34'(mult_l); a_opb = rd_fwd; end
      S_BS_MUL: begin a_start = !issued; a_opa = 34'(rd_up); a_opb = x_prev; end
      S_BS_DIV: begin a_start = !issued; a_op = OP_DIV; a_opa = bs_num; a_opb = rd_piv; end
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      row_count     <= '0;
      singular_seen <= 1'b0;
      out_valid     <= 1'b0;
      issued        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            l_low <= lower; l_diag <= diag; l_rhs <= rhs_value; l_upper <= upper;
            cur      <= row_count;
            nrows_m1 <= row_count;
            bs_top   <= last_row || (row_count == AW'(MAX_ROWS - 1));
            if (singular_seen) begin
              state <= S_WRITE;
            end else if (row_count == '0) begin
              pivot_mem[0] <= diag;
              fwd_mem[0]   <= rhs_value;
              upper_mem[0] <= upper;
              if (diag == '0) singular_seen <= 1'b1;
              state <= S_WRITE;
            end else begin
              rd_piv <= pivot_mem[row_count - 1'b1];
              rd_up  <= upper_mem[row_count - 1'b1];
              rd_fwd <= fwd_mem[row_count - 1'b1];
              state  <= S_DIV_L;
            end
          end
        end
        S_DIV_L: begin
          issued <= 1'b1;
          if (a_done) begin issued <= 1'b0; mult_l <= a_res; state <= S_MUL_D; end
        end
        S_MUL_D: begin
          issued <= 1'b1;
          if (a_done) begin
            issued  <= 1'b0;
            new_piv <= sat66(66'(l_diag) - 66'(a_res));
            state   <= S_MUL_Y;
          end
        end
        S_MUL_Y: begin
          issued <= 1'b1;
          if (a_done) begin
            issued         <= 1'b0;
            pivot_mem[cur] <= new_piv;
            upper_mem[cur] <= l_upper;
            fwd_mem[cur]   <= sat66(66'(l_rhs) - 66'(a_res));
            if (new_piv == '0) singular_seen <= 1'b1;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (!bs_top) begin
            row_count <= row_count + 1'b1;
            state     <= S_IDLE;
          end else if (singular_seen) begin
            cur   <= '0;
            state <= S_EMIT_RD;
          end else begin
            state <= S_BS_RD;
          end
        end
        S_BS_RD: begin
          rd_piv <= pivot_mem[cur];
          rd_up  <= upper_mem[cur];
          rd_fwd <= fwd_mem[cur];
          state  <= (cur == nrows_m1) ? S_BS_DIV : S_BS_MUL;
          bs_num <= 34'(fwd_mem[cur]);
        end
        S_BS_MUL: begin
          issued <= 1'b1;
          if (a_done) begin issued <= 1'b0; bs_num <= diff34; state <= S_BS_DIV; end
        end
        S_BS_DIV: begin
          issued <= 1'b1;
          if (a_done) begin
            issued     <= 1'b0;
            x_mem[cur] <= a_res;
            x_prev     <= a_res;
            state      <= S_BS_NEXT;
          end
        end
        S_BS_NEXT: begin
          if (cur == '0) begin
            state <= S_EMIT_RD;
          end else begin
            cur   <= cur - 1'b1;
            state <= S_BS_RD;
          end
        end
        S_EMIT_RD: begin
          rd_x  <= x_mem[cur];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid) begin
            out_valid   <= 1'b1;
            solution    <= singular_seen ? '0 : rd_x;
            row_index   <= IDX_W'(cur);
            singular    <= singular_seen;
            last_result <= (cur == nrows_m1);
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (cur == nrows_m1) begin
              row_count     <= '0;
              singular_seen <= 1'b0;
              state         <= S_IDLE;
            end else begin
              cur   <= cur + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[verif/tridiagonal_system_solver_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tridiagonal solver testbench
// Feeds systems of rows through the input channel, solves each system again
// in a fixed-point Thomas algorithm model and checks every solution element.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver_unit_tb;
  import tds_pkg::*;

  localparam int FRAC   = FRAC_BITS_DEF;
  localparam int NROWS  = MAX_ROWS_DEF;
  localparam int QUIET_LIMIT = 40000;
  localparam int ONE    = 32'sh0001_0000;

  typedef struct {
    int lo;
    int dg;
    int up;
    int rh;
    bit lst;
    bit has_exp;
    int exp_x;
    bit exp_sing;
  } row_t;

  typedef struct {
    int           x;
    bit [IDX_W-1:0] idx;
    bit           sing;
    bit           fin;
  } sol_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] lower = '0, diag = '0, upper = '0, rhs_value = '0;
  logic last_row = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] solution;
  logic [IDX_W-1:0] row_index;
  logic singular, last_result;

  tridiagonal_system_solver_unit dut (.*);

  always #10 clk = ~clk;

  // Solver model state.
  int pivots [NROWS];
  int uppers [NROWS];
  int fwd_rhs[NROWS];
  int rows_seen;
  bit zero_pivot;
  sol_t pending_sols[$];

  int errors = 0;
  int tx_idle = 0, rx_idle = 0;
  int quiet = 0;
  int sent = 0;
  row_t dir_rows[$];

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic int fx_mul(int a, int b);
    longint p;
    longint m;
    p = longint'(a) * longint'(b);
    m = (p < 0) ? -p : p;
    m = m >>> FRAC;
    return sat((p < 0) ? -m : m);
  endfunction

  function automatic int fx_div(longint num, int den);
    longint unsigned un, ud, q;
    longint sq;
    un = longint'((num < 0) ? -num : num) << FRAC;
    ud = (den < 0) ? longint'(-longint'(den)) : longint'(den);
    q = un / ud;
    sq = longint'(q);
    return sat(((num < 0) != (den < 0)) ? -sq : sq);
  endfunction

  // Forward elimination per row; back substitution when the system closes.
  function automatic void solve_row(row_t rw);
    int r, n, l;
    bit fin;
    int xs[NROWS];
    sol_t s;
    r = (rows_seen >= NROWS) ? NROWS - 1 : rows_seen;
    fin = rw.lst || (r == NROWS - 1);
    if (!zero_pivot) begin
      if (r == 0) begin
        pivots[0] = rw.dg;
        fwd_rhs[0] = rw.rh;
      end else begin
        l = fx_div(longint'(rw.lo), pivots[r-1]);
        pivots[r] = sat(longint'(rw.dg) - longint'(fx_mul(l, uppers[r-1])));
        fwd_rhs[r] = sat(longint'(rw.rh) - longint'(fx_mul(l, fwd_rhs[r-1])));
      end
      uppers[r] = rw.up;
      if (pivots[r] == 0) zero_pivot = 1'b1;
    end
    if (!fin) begin
      rows_seen = r + 1;
      return;
    end
    n = r + 1;
    if (!zero_pivot) begin
      xs[n-1] = fx_div(longint'(fwd_rhs[n-1]), pivots[n-1]);
      for (int i = n - 2; i >= 0; i--)
        xs[i] = fx_div(longint'(fwd_rhs[i]) - longint'(fx_mul(uppers[i], xs[i+1])),
                       pivots[i]);
    end
    for (int i = 0; i < n; i++) begin
      s.x = zero_pivot ? 0 : xs[i];
      s.idx = i[IDX_W-1:0];
      s.sing = zero_pivot;
      s.fin = (i == n - 1);
      // A single-row system with a hand-worked answer overrides the model.
      if (rw.has_exp && n == 1) begin
        s.x = rw.exp_x;
        s.sing = rw.exp_sing;
      end
      pending_sols.push_back(s);
    end
    rows_seen = 0;
    zero_pivot = 1'b0;
  endfunction

  task automatic send_row(row_t rw);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    lower <= rw.lo;
    diag <= rw.dg;
    upper <= rw.up;
    rhs_value <= rw.rh;
    last_row <= rw.lst;
    do @(posedge clk); while (!in_ready);
    solve_row(rw);
    sent++;
    @(negedge clk);
  endtask

  function automatic row_t mk(int lo, int dg, int up, int rh, bit lst,
                              bit he = 0, int ex = 0, bit es = 0);
    row_t rw;
    rw.lo = lo; rw.dg = dg; rw.up = up; rw.rh = rh; rw.lst = lst;
    rw.has_exp = he; rw.exp_x = ex; rw.exp_sing = es;
    return rw;
  endfunction

  // Random system: mostly diagonally dominant, sometimes raw noise.
  task automatic send_system(int n, bit wrap);
    bit noisy;
    row_t rw;
    noisy = ($urandom_range(99) < 20);
    for (int i = 0; i < n; i++) begin
      if (noisy) begin
        rw = mk($urandom, $urandom, $urandom, $urandom, 1'b0);
      end else begin
        rw.lo = $signed($urandom_range(4 * ONE)) - 2 * ONE;
        rw.up = $signed($urandom_range(4 * ONE)) - 2 * ONE;
        rw.dg = $signed($urandom_range(12 * ONE)) + 5 * ONE;
        if ($urandom_range(1)) rw.dg = -rw.dg;
        rw.rh = $signed($urandom_range(200 * ONE)) - 100 * ONE;
        rw.has_exp = 0;
      end
      if (i == 0 && $urandom_range(99) < 5) rw.dg = 0;
      rw.lst = (i == n - 1) && !wrap;
      send_row(rw);
    end
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle);

  always @(posedge clk) begin
    sol_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_sols.size() == 0) begin
        $error("solution element with none expected: row_index %0d", row_index);
        errors++;
      end else begin
        e = pending_sols.pop_front();
        if (solution !== e.x) begin
          $error("solution: expected %h, got %h", e.x, solution);
          errors++;
        end
        if (row_index !== e.idx) begin
          $error("row_index: expected %0d, got %0d", e.idx, row_index);
          errors++;
        end
        if (singular !== e.sing) begin
          $error("singular: expected %0b, got %0b", e.sing, singular);
          errors++;
        end
        if (last_result !== e.fin) begin
          $error("last_result: expected %0b, got %0b", e.fin, last_result);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int phase;
    rows_seen = 0;
    zero_pivot = 0;
    // Single-row systems with answers worked by hand.
    dir_rows.push_back(mk(0, ONE, 0, 2 * ONE, 1, 1, 2 * ONE, 0));
    dir_rows.push_back(mk(0, 0, 0, 32'sh7FFF_FFFF, 1, 1, 0, 1));
    dir_rows.push_back(mk(0, 1, 0, 32'sh7FFF_FFFF, 1, 1, 32'sh7FFF_FFFF, 0));
    dir_rows.push_back(mk(0, 1, 0, 32'sh8000_0000, 1, 1, 32'sh8000_0000, 0));
    dir_rows.push_back(mk(0, 32'sh8000_0000, 0, 32'sh8000_0000, 1, 1, ONE, 0));
    dir_rows.push_back(mk(-1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1, 1, 0, 0));
    // Three-row well-conditioned system.
    dir_rows.push_back(mk(0, 4 * ONE, ONE, 5 * ONE, 0));
    dir_rows.push_back(mk(ONE, 4 * ONE, ONE, 6 * ONE, 0));
    dir_rows.push_back(mk(ONE, 4 * ONE, 0, 5 * ONE, 1));
    // Zero pivot in the middle row; the row after it is not eliminated.
    dir_rows.push_back(mk(0, ONE, ONE, ONE, 0));
    dir_rows.push_back(mk(ONE, ONE, 32'sh7FFF_FFFF, 2 * ONE, 0));
    dir_rows.push_back(mk(-1, 32'sh8000_0000, 0, 3 * ONE, 1));
    // Extreme values in every field of two two-row systems.
    dir_rows.push_back(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          32'sh7FFF_FFFF, 0));
    dir_rows.push_back(mk(32'sh8000_0000, 32'sh8000_0000, -1, 32'sh8000_0000, 1));
    dir_rows.push_back(mk(32'sh7FFF_FFFF, 1, 32'sh8000_0000, -1, 0));
    dir_rows.push_back(mk(32'sh7FFF_FFFF, -1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle = 11;
    rx_idle = 47;
    foreach (dir_rows[i]) send_row(dir_rows[i]);

    phase = 0;
    while (sent < 250) begin
      if (phase == 0 && sent >= 100) begin
        phase = 1;
        tx_idle = 47;
        rx_idle = 11;
      end else if (phase == 1 && sent >= 185) begin
        phase = 2;
        tx_idle = 0;
        rx_idle = 0;
        // Row 63 closes the system even without last_row.
        send_system(NROWS, 1'b1);
      end
      send_system($urandom_range(99) < 15 ? 1 : $urandom_range(2, 8), 1'b0);
    end
    in_valid <= 1'b0;
    while (pending_sols.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
